FILE: design/dhip_pkg.sv
// Package for the decimal/hex identifier parser: item and state types,
// status codes, length limits and character class functions.
// No dependencies; used by every module of the block.
`default_nettype none

package dhip_pkg;

   // Status codes of a result item
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_EMPTY      = 2'd1;
   localparam logic [1:0] STATUS_BASE64     = 2'd2;
   localparam logic [1:0] STATUS_UNREADABLE = 2'd3;

   // Length limits, in content characters
   localparam logic [4:0] DEC_MAX_LEN    = 5'd20;
   localparam logic [4:0] HEX_FULL_LEN   = 5'd16;
   localparam logic [4:0] PREFIX_MAX_LEN = 5'd18;  // "0x" plus 16 digits
   localparam logic [4:0] PREFIX_LEN     = 5'd2;
   localparam logic [4:0] B64_LEN_SHORT  = 5'd11;
   localparam logic [4:0] B64_LEN_LONG   = 5'd12;
   localparam logic [4:0] COUNT_MAX      = 5'd31;

   // Bit positions in the class flags
   localparam int CLS_DEC = 0;
   localparam int CLS_HEX = 1;
   localparam int CLS_B64 = 2;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] id_value;
   } rsp_item_type;

   // Scan state carried from one character to the next
   typedef struct packed {
      logic        seen_content;
      logic        pending_blank;
      logic        inner_blank;
      logic [4:0]  char_count;
      logic        first_is_zero;
      logic        has_prefix;
      logic        prefix_bad;
      logic [63:0] decimal_acc;
      logic        decimal_overflow;
      logic [63:0] hex_acc;
      logic [2:0]  class_flags;
   } scan_state_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7a);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5a);
   endfunction

   // space, tab, CR, LF
   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // Nibble value of a hex digit, zero for anything else
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] nib;
      nib = 4'd0;
      if (is_digit(c))
         nib = c[3:0];
      else if (is_hex(c))
         nib = c[3:0] + 4'd9;   // 'a'/'A' have low nibble 1
      return nib;
   endfunction

   // Standard base64 alphabet including '+', '/' and '='
   function automatic logic is_b64(input logic [7:0] c);
      return is_digit(c) || is_lower(c) || is_upper(c) ||
             (c == 8'h2b) || (c == 8'h2f) || (c == 8'h3d);
   endfunction

   function automatic logic is_x(input logic [7:0] c);
      return (c == 8'h78) || (c == 8'h58);
   endfunction

   localparam scan_state_type SCAN_RESET = '{
      seen_content:     1'b0,
      pending_blank:    1'b0,
      inner_blank:      1'b0,
      char_count:       5'd0,
      first_is_zero:    1'b0,
      has_prefix:       1'b0,
      prefix_bad:       1'b0,
      decimal_acc:      64'd0,
      decimal_overflow: 1'b0,
      hex_acc:          64'd0,
      class_flags:      3'b111
   };

endpackage

`default_nettype wire

FILE: design/dhip_scan.sv
// Scan state of the parser: folds one character per cycle into the
// accumulators and flags, and clears back to reset at end of text.
// Depends on dhip_pkg.
`default_nettype none

module dhip_scan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    char_en,
   input  wire logic                    clear,
   input  wire logic [7:0]              character,
   output dhip_pkg::scan_state_type     scan_state
);
   import dhip_pkg::*;

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type upd;
   logic [67:0]    dec_sum;
   logic [4:0]     pos;

   // Decimal multiply-add: acc*10 + digit, carry bits flag overflow
   assign dec_sum = {1'b0, state_ff.decimal_acc, 3'b000}
                  + {3'b000, state_ff.decimal_acc, 1'b0}
                  + {64'd0, character[3:0]};

   // Effect of one character on the scan state
   always_comb begin
      upd = state_ff;
      pos = state_ff.char_count;
      if (is_blank(character)) begin
         if (state_ff.seen_content)
            upd.pending_blank = 1'b1;
      end else begin
         if (state_ff.pending_blank)
            upd.inner_blank = 1'b1;
         upd.seen_content = 1'b1;
         if (pos != COUNT_MAX)
            upd.char_count = pos + 5'd1;

         if (pos == 5'd0)
            upd.first_is_zero = (character == 8'h30);
         else if (pos == 5'd1)
            upd.has_prefix = state_ff.first_is_zero && is_x(character);
         else if (state_ff.has_prefix && !is_hex(character))
            upd.prefix_bad = 1'b1;

         upd.hex_acc = {state_ff.hex_acc[59:0], hex_nibble(character)};

         if (is_digit(character)) begin
            if (!state_ff.decimal_overflow) begin
               if (|dec_sum[67:64])
                  upd.decimal_overflow = 1'b1;
               else
                  upd.decimal_acc = dec_sum[63:0];
            end
         end else begin
            upd.class_flags[CLS_DEC] = 1'b0;
         end
         if (!is_hex(character))
            upd.class_flags[CLS_HEX] = 1'b0;
         if (!is_b64(character))
            upd.class_flags[CLS_B64] = 1'b0;
      end
   end

   // End of text wins over a character
   always_comb begin
      state_in = state_ff;
      if (clear)
         state_in = SCAN_RESET;
      else if (char_en)
         state_in = upd;
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= SCAN_RESET;
      else
         state_ff <= state_in;
   end

   assign scan_state = state_ff;

endmodule

`default_nettype wire

FILE: design/dhip_verdict.sv
// Verdict logic: turns the scan state at end of text into a status code
// and identifier value, in preference order prefix, decimal, hex, base64.
// Depends on dhip_pkg.
`default_nettype none

module dhip_verdict (
   input  wire dhip_pkg::scan_state_type scan_state,
   output dhip_pkg::rsp_item_type        verdict
);
   import dhip_pkg::*;

   logic hex_zero;
   logic dec_zero;

   assign hex_zero = (scan_state.hex_acc == 64'd0);
   assign dec_zero = (scan_state.decimal_acc == 64'd0);

   always_comb begin
      verdict.status   = STATUS_UNREADABLE;
      verdict.id_value = 64'd0;
      if (!scan_state.seen_content) begin
         verdict.status = STATUS_EMPTY;
      end else if (scan_state.inner_blank) begin
         verdict.status = STATUS_UNREADABLE;
      end else if ((scan_state.char_count > PREFIX_LEN) && scan_state.has_prefix) begin
         // 0x form: 1 to 16 hex digits, nonzero
         if (!((scan_state.char_count > PREFIX_MAX_LEN) || scan_state.prefix_bad ||
               hex_zero)) begin
            verdict.status   = STATUS_OK;
            verdict.id_value = scan_state.hex_acc;
         end
      end else if (scan_state.class_flags[CLS_DEC]) begin
         if (!((scan_state.char_count > DEC_MAX_LEN) || scan_state.decimal_overflow ||
               dec_zero)) begin
            verdict.status   = STATUS_OK;
            verdict.id_value = scan_state.decimal_acc;
         end
      end else if (scan_state.class_flags[CLS_HEX] &&
                   (scan_state.char_count == HEX_FULL_LEN)) begin
         if (!hex_zero) begin
            verdict.status   = STATUS_OK;
            verdict.id_value = scan_state.hex_acc;
         end
      end else if (scan_state.class_flags[CLS_B64] &&
                   ((scan_state.char_count == B64_LEN_SHORT) ||
                    (scan_state.char_count == B64_LEN_LONG))) begin
         verdict.status = STATUS_BASE64;
      end
   end

endmodule

`default_nettype wire

FILE: design/decimal_hex_id_parser_top.sv
// Top level of the decimal/hex identifier parser: input register, scan
// state, verdict logic and result register.
// Depends on dhip_pkg, dhip_scan and dhip_verdict.
//
// Usage: send a text one character per req item (end_of_text low), then
// one req item with end_of_text high. Character items give no result; the
// end item gives exactly one rsp item with status (ok, empty, base64 form,
// unreadable) and the 64-bit identifier, zero unless status is ok.
// Blanks at either end of the text are ignored.
// Throughput: one req item per cycle while no end item waits for the result
// register; each character is folded into the scan state by combinational
// logic (a shift-add by ten plus compares) ahead of the scan register.
// Result path: an accepted end item sits in the input register, then the
// verdict is loaded into the result register once that register is free.
// Reset: synchronous; clears the scan state to an empty text and drops
// both valid registers.
// Stall: while rsp_stall holds a waiting result, character items keep
// flowing; a following end item waits in the input register and req_stall
// rises until the result register frees up.
`default_nettype none

module decimal_hex_id_parser_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire dhip_pkg::req_item_type req_item,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output dhip_pkg::rsp_item_type      rsp_item
);
   import dhip_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   req_item_type   in_item_ff;
   req_item_type   in_item_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   rsp_item_in;
   logic           out_free;
   logic           proc_go;
   logic           proc_end;
   scan_state_type scan_state;
   rsp_item_type   verdict;

   // Pipeline control: only an end item needs the result register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_go   = in_valid_ff && (!in_item_ff.end_of_text || out_free);
   assign proc_end  = proc_go && in_item_ff.end_of_text;
   assign req_stall = in_valid_ff && !proc_go;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
      in_item_ff <= in_item_in;
   end

   dhip_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .char_en    (proc_go && !in_item_ff.end_of_text),
      .clear      (proc_end),
      .character  (in_item_ff.character),
      .scan_state (scan_state)
   );

   dhip_verdict u_verdict (
      .scan_state (scan_state),
      .verdict    (verdict)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (proc_end) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = verdict;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for decimal_hex_id_parser_top: a queue-fed driver sends texts
// and a monitor checks every verdict against an in-bench model of the identifier parser.
// Depends on dhip_pkg and the decimal_hex_id_parser_top RTL.
`timescale 1ns / 100ps

module testbench;
   import dhip_pkg::*;

   localparam int    HOLD_CYCLES = 300;
   localparam int    PHASE_ITEMS = 230;
   localparam string DEC_DIGITS  = "0123456789";
   localparam string HEX_DIGITS  = "0123456789abcdefABCDEF";
   localparam string B64_CHARS   =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
   localparam string BLANK_CHARS = " \t\r\n";
   localparam string NON_HEX     = "gGxX_.z-";
   localparam string U64_MAX_TEXT  = "18446744073709551615";
   localparam string U64_OVER_TEXT = "18446744073709551616";

   // Scan state of the text being assembled
   typedef struct packed {
      logic        started;
      logic        blank_after_text;
      logic        split_text;
      logic [4:0]  length;
      logic        lead_zero;
      logic        prefixed;
      logic        prefix_broken;
      logic [63:0] dec_value;
      logic        dec_wrapped;
      logic [63:0] nibble_acc;
      logic [2:0]  form_flags;
   } text_scan_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   req_item_type  pending_items[$];
   rsp_item_type  expected_ids[$];
   logic [7:0]    text_buf[$];
   text_scan_type scan;
   int            items_queued = 0;
   int            mismatch_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_left = 0;
   logic          hold_arm = 1'b0;
   logic          hold_taken = 1'b0;

   decimal_hex_id_parser_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic logic char_is_blank(input logic [7:0] c);
      return c == " " || c == "\t" || c == "\r" || c == "\n";
   endfunction

   function automatic logic char_is_decimal(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // -1 for anything that is not a hex digit
   function automatic int hex_digit_value(input logic [7:0] c);
      if (char_is_decimal(c))
         return int'(c) - int'("0");
      if (c >= "a" && c <= "f")
         return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F")
         return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic logic char_in_base64(input logic [7:0] c);
      return char_is_decimal(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             c == "+" || c == "/" || c == "=";
   endfunction

   function automatic void clear_scan();
      scan = '0;
      scan.form_flags = 3'b111;
   endfunction

   function automatic void fold_character(input logic [7:0] c);
      int         nib;
      logic [4:0] pos;
      logic [67:0] wide;
      nib = hex_digit_value(c);
      if (char_is_blank(c)) begin
         if (scan.started)
            scan.blank_after_text = 1'b1;
      end else begin
         if (scan.blank_after_text)
            scan.split_text = 1'b1;
         scan.started = 1'b1;
         pos = scan.length;
         if (scan.length != COUNT_MAX)
            scan.length = scan.length + 5'd1;
         if (pos == 5'd0)
            scan.lead_zero = (c == "0");
         else if (pos == 5'd1)
            scan.prefixed = scan.lead_zero && (c == "x" || c == "X");
         else if (scan.prefixed && nib < 0)
            scan.prefix_broken = 1'b1;
         scan.nibble_acc = {scan.nibble_acc[59:0], (nib < 0) ? 4'd0 : 4'(nib)};
         if (char_is_decimal(c)) begin
            if (!scan.dec_wrapped) begin
               wide = {4'd0, scan.dec_value} * 68'd10 + 68'(c - "0");
               if (wide[67:64] != 4'd0)
                  scan.dec_wrapped = 1'b1;
               else
                  scan.dec_value = wide[63:0];
            end
         end else
            scan.form_flags[CLS_DEC] = 1'b0;
         if (nib < 0)
            scan.form_flags[CLS_HEX] = 1'b0;
         if (!char_in_base64(c))
            scan.form_flags[CLS_B64] = 1'b0;
      end
   endfunction

   // Verdict for the text scanned so far, in order of preference
   function automatic rsp_item_type judge_text();
      rsp_item_type r;
      r.status   = STATUS_UNREADABLE;
      r.id_value = 64'd0;
      if (!scan.started)
         r.status = STATUS_EMPTY;
      else if (scan.split_text)
         r.status = STATUS_UNREADABLE;
      else if (scan.length > PREFIX_LEN && scan.prefixed) begin
         if (!(scan.length > PREFIX_MAX_LEN || scan.prefix_broken ||
               scan.nibble_acc == 0)) begin
            r.status   = STATUS_OK;
            r.id_value = scan.nibble_acc;
         end
      end else if (scan.form_flags[CLS_DEC]) begin
         if (!(scan.length > DEC_MAX_LEN || scan.dec_wrapped || scan.dec_value == 0)) begin
            r.status   = STATUS_OK;
            r.id_value = scan.dec_value;
         end
      end else if (scan.form_flags[CLS_HEX] && scan.length == HEX_FULL_LEN) begin
         if (scan.nibble_acc != 0) begin
            r.status   = STATUS_OK;
            r.id_value = scan.nibble_acc;
         end
      end else if (scan.form_flags[CLS_B64] &&
                   (scan.length == B64_LEN_SHORT || scan.length == B64_LEN_LONG))
         r.status = STATUS_BASE64;
      return r;
   endfunction

   function automatic void predict_item(input req_item_type item);
      if (!item.end_of_text)
         fold_character(item.character);
      else begin
         expected_ids.push_back(judge_text());
         clear_scan();
      end
   endfunction

   // --------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_item  <= '0;
         clear_scan();
      end else begin
         if (req_valid && !req_stall)
            predict_item(req_item);
         // slot is free: offer the next item unless idling this cycle
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_item  <= pending_items.pop_front();
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------- monitor

   always @(posedge clock) begin
      int           hold_next;
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ids.size() == 0) begin
               $error("unexpected result: status %0d id_value %h",
                      rsp_item.status, rsp_item.id_value);
               mismatch_count++;
            end else begin
               want = expected_ids.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  mismatch_count++;
               end
               if (rsp_item.id_value !== want.id_value) begin
                  $error("id_value: expected %h, got %h", want.id_value, rsp_item.id_value);
                  mismatch_count++;
               end
            end
         end
         // one long hold-off when armed, random stalls otherwise
         hold_next = hold_left;
         if (hold_left != 0)
            hold_next = hold_left - 1;
         else if (hold_arm && !hold_taken) begin
            hold_next  = HOLD_CYCLES;
            hold_taken <= 1'b1;
         end
         hold_left <= hold_next;
         rsp_stall <= (hold_next != 0) || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // ------------------------------------------------------------- stimulus

   task automatic queue_item(input logic [7:0] c, input logic eot);
      req_item_type item;
      item.character   = c;
      item.end_of_text = eot;
      pending_items.push_back(item);
      items_queued++;
   endtask

   // Send text_buf as one text, closed by an end item with a junk character
   task automatic queue_text();
      foreach (text_buf[i])
         queue_item(text_buf[i], 1'b0);
      queue_item(8'($urandom_range(0, 255)), 1'b1);
      text_buf.delete();
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++)
         text_buf.push_back(s[i]);
   endtask

   task automatic add_from(input string alphabet, input int count);
      for (int i = 0; i < count; i++)
         text_buf.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
   endtask

   task automatic build_random_text();
      int n;
      text_buf.delete();
      case ($urandom_range(0, 9))
         0, 1: begin
            // decimal, including the 64-bit limit and just past it
            case ($urandom_range(0, 7))
               0: add_string(U64_MAX_TEXT);
               1: add_string(U64_OVER_TEXT);
               2: add_from(DEC_DIGITS, $urandom_range(18, 21));
               default: add_from(DEC_DIGITS, $urandom_range(1, 12));
            endcase
         end
         2, 3: begin
            // prefixed hex, sometimes too long, broken or zero
            text_buf.push_back("0");
            text_buf.push_back($urandom_range(0, 1) ? "x" : "X");
            n = ($urandom_range(0, 7) == 0) ? 17 : $urandom_range(1, 16);
            if ($urandom_range(0, 9) == 0)
               add_from("0", n);
            else
               add_from(HEX_DIGITS, n);
            if ($urandom_range(0, 7) == 0)
               text_buf[$urandom_range(2, text_buf.size() - 1)] =
                  NON_HEX[$urandom_range(0, NON_HEX.len() - 1)];
         end
         4: begin
            // bare hex, full length mostly
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 17) : 16;
            if ($urandom_range(0, 9) == 0)
               add_from("0", n);
            else
               add_from(HEX_DIGITS, n);
         end
         5: add_from(B64_CHARS, ($urandom_range(0, 5) == 0) ? $urandom_range(10, 13)
                                                            : $urandom_range(11, 12));
         6: begin
            // raw bytes, long enough to saturate the length count
            n = $urandom_range(0, 40);
            for (int i = 0; i < n; i++)
               text_buf.push_back(8'($urandom_range(0, 255)));
         end
         7: begin
            add_from(DEC_DIGITS, $urandom_range(1, 5));
            add_from(BLANK_CHARS, $urandom_range(1, 2));
            add_from(HEX_DIGITS, $urandom_range(1, 5));
         end
         8: add_from(BLANK_CHARS, $urandom_range(0, 3));
         default: begin
            // near misses on the prefix
            text_buf.push_back("0");
            text_buf.push_back(8'($urandom_range(0, 255)));
            add_from(HEX_DIGITS, $urandom_range(0, 16));
         end
      endcase
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++)
            text_buf.push_front(BLANK_CHARS[$urandom_range(0, 3)]);
      end
      if ($urandom_range(0, 3) == 0)
         add_from(BLANK_CHARS, $urandom_range(1, 3));
   endtask

   task automatic wait_for_drain();
      while (pending_items.size() != 0 || expected_ids.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int start;
      @(negedge clock);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
         build_random_text();
         queue_text();
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed texts: empty, blanks only, bare prefix, inner blank,
      // extreme bytes, a single-digit value and zero
      queue_text();
      add_string(" \t\r\n");
      queue_text();
      add_string("0x");
      queue_text();
      add_string("1 2");
      queue_text();
      text_buf.push_back(8'h00);
      text_buf.push_back(8'hff);
      queue_text();
      add_string("7");
      queue_text();
      add_string("0");
      queue_text();
      wait_for_drain();

      run_phase(0, 0);
      run_phase(53, 0);
      run_phase(0, 53);
      run_phase(17, 17);

      // long receiver hold-off while the sender keeps going
      @(negedge clock);
      hold_arm = 1'b1;
      run_phase(0, 0);

      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
